@@ rtl/cdtb_pkg.sv @@
// ----------------------------------------------------------------------------
// cdtb_pkg
// Shared types and constants for the countdown timer bank.
// ----------------------------------------------------------------------------
package cdtb_pkg;

  localparam int unsigned NUM_TIMERS  = 16;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned ADDR_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned IDX_EXT_W   = 9;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned EXP_W       = 16;
  localparam int unsigned TICK_W      = 32;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ARM  = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_READ = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [3:0]  timer_index;
    logic [31:0] count_value;
  } in_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic [TICK_W-1:0] tick_count;
    logic [EXP_W-1:0]  expiry_count;
  } out_rsp_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic walk_last;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ rtl/cdtb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdtb_ctrl
// Sequencer that accepts requests and steps the tick walk over the timers.
// ----------------------------------------------------------------------------
module cdtb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cdtb_pkg::dp_sts_t sts_i,
  output cdtb_pkg::dp_cmd_t cmd_o
);
  import cdtb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q;

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE) && !sts_i.out_busy;
    cmd_o.accept  = in_valid_i && in_ready_o;
    cmd_o.step    = (state_q == ST_WALK);
    cmd_o.finish  = cmd_o.step && sts_i.walk_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept && sts_i.is_tick) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (sts_i.walk_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/cdtb_datapath.sv @@
// ----------------------------------------------------------------------------
// cdtb_datapath
// Timer table, per-entry tick update, tick counter and response register.
// ----------------------------------------------------------------------------
module cdtb_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdtb_pkg::in_req_t  in_req_i,
  input  cdtb_pkg::dp_cmd_t  cmd_i,
  output cdtb_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdtb_pkg::out_rsp_t out_rsp_o
);
  import cdtb_pkg::*;

  logic [COUNT_WIDTH-1:0] counter_q [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] repeat_q  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] pending_q [NUM_TIMERS];
  logic [EXP_W-1:0]       expiry_q  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  armed_q;

  logic [ADDR_W-1:0] walk_idx_q;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [TICK_W-1:0] ticks_q;
  logic              out_valid_q;
  out_rsp_t          out_rsp_q;

  logic [IDX_EXT_W-1:0]   req_idx_ext;
  logic [IDX_EXT_W-1:0]   walk_idx_ext;
  logic                   req_hit;
  logic [ADDR_W-1:0]      req_addr;
  logic [ADDR_W-1:0]      addr;
  logic [COUNT_WIDTH-1:0] req_val;
  logic [COUNT_WIDTH-1:0] cnt_rd, rep_rd, pend_rd;
  logic [EXP_W-1:0]       exp_rd;
  logic                   armed_rd;
  logic [COUNT_WIDTH-1:0] cnt_dec, cnt_new, pend_new;
  logic [EXP_W-1:0]       exp_new;
  logic                   expired;

  always_comb begin
    req_idx_ext  = IDX_EXT_W'(in_req_i.timer_index);
    walk_idx_ext = IDX_EXT_W'(walk_idx_q);
    req_hit      = req_idx_ext < IDX_EXT_W'(NUM_TIMERS);
    req_addr     = req_idx_ext[ADDR_W-1:0];
    req_val      = COUNT_WIDTH'(in_req_i.count_value);
    addr         = cmd_i.step ? walk_idx_q : req_addr;

    cnt_rd   = counter_q[addr];
    rep_rd   = repeat_q[addr];
    pend_rd  = pending_q[addr];
    exp_rd   = expiry_q[addr];
    armed_rd = armed_q[addr];

    cnt_dec  = cnt_rd - COUNT_WIDTH'(1);
    expired  = (cnt_rd != '0) && (cnt_dec == '0);
    cnt_new  = cnt_rd;
    exp_new  = exp_rd;
    pend_new = pend_rd;
    if (cnt_rd != '0) begin
      cnt_new = cnt_dec;
      if (expired) begin
        exp_new = exp_rd + EXP_W'(1);
        if (rep_rd != '0) begin
          cnt_new = rep_rd;
        end
      end
    end
    if (pend_rd != '0) begin
      cnt_new  = pend_rd;
      pend_new = '0;
    end

    mask_d = mask_q;
    if (armed_rd && expired && (walk_idx_ext < IDX_EXT_W'(MASK_W))) begin
      mask_d[walk_idx_ext[3:0]] = 1'b1;
    end

    sts_o.is_tick   = (in_req_i.mode == MODE_TICK);
    sts_o.walk_last = (walk_idx_q == ADDR_W'(NUM_TIMERS - 1));
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_TIMERS); i++) begin
        counter_q[i] <= '0;
        repeat_q[i]  <= '0;
        pending_q[i] <= '0;
        expiry_q[i]  <= '0;
      end
      armed_q <= '0;
    end else if (cmd_i.step) begin
      if (armed_rd) begin
        counter_q[walk_idx_q] <= cnt_new;
        pending_q[walk_idx_q] <= pend_new;
        expiry_q[walk_idx_q]  <= exp_new;
      end
    end else if (cmd_i.accept && req_hit) begin
      unique case (in_req_i.mode) inside
        MODE_ARM: begin
          armed_q[req_addr]   <= 1'b1;
          repeat_q[req_addr]  <= req_val;
          counter_q[req_addr] <= req_val;
          expiry_q[req_addr]  <= '0;
          pending_q[req_addr] <= '0;
        end
        MODE_LOAD: begin
          pending_q[req_addr] <= req_val;
        end
        MODE_TICK, MODE_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_idx_q  <= '0;
      mask_q      <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish || (cmd_i.accept && !sts_o.is_tick)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.step) begin
        if (cmd_i.finish) begin
          walk_idx_q <= '0;
          mask_q     <= '0;
          ticks_q    <= ticks_q + TICK_W'(1);
        end else begin
          walk_idx_q <= walk_idx_q + ADDR_W'(1);
          mask_q     <= mask_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_rsp_q.expired_mask <= mask_d;
      out_rsp_q.tick_count   <= ticks_q + TICK_W'(1);
      out_rsp_q.expiry_count <= '0;
    end else if (cmd_i.accept && !sts_o.is_tick) begin
      out_rsp_q.expired_mask <= '0;
      out_rsp_q.tick_count   <= ticks_q;
      out_rsp_q.expiry_count <= ((in_req_i.mode == MODE_READ) && req_hit) ? exp_rd : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

@@ rtl/countdown_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_bank_core
// Bank of countdown timers with auto reload, stepped by a common tick.
// ----------------------------------------------------------------------------
// An arm, load or read request takes one cycle and its response is in the
// output register on the next cycle. A tick request is accepted and then
// walks the timers in index order, updating a single timer table entry per
// cycle, and registers its response when the walk finishes. A new
// request is taken as soon as the block is idle and the output register is
// empty or being emptied.
module countdown_timer_bank_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cdtb_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdtb_pkg::out_rsp_t out_rsp_o
);
  import cdtb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cdtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdtb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_no_accept_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_ready_o)
    else $error("Request accepted during a tick walk.");

  a_tick_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && sts.is_tick) |=> cmd.step)
    else $error("Tick request did not start a walk.");

  a_finish_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("Finished tick walk produced no response.");

  a_walk_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !sts.out_busy)
    else $error("Output register still held during a tick walk.");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for countdown_timer_bank_core. A scoreboard keeps
// its own copy of the timer table, predicts the response of every accepted
// request and compares each returned response field by field. Directed
// requests cover the corner cases, then random traffic with bursty requests,
// a patterned response stall and long receiver hold-offs exercises the
// handshakes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdtb_pkg::*;

  class timer_scoreboard;
    logic [COUNT_WIDTH-1:0] counter_q   [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] reload_q    [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] load_q      [NUM_TIMERS];
    logic [EXP_W-1:0]       expiries_q  [NUM_TIMERS];
    bit                     armed_q     [NUM_TIMERS];
    logic [TICK_W-1:0]      ticks_q;
    out_rsp_t               expected_q[$];
    int                     errors;

    function new();
      for (int i = 0; i < NUM_TIMERS; i++) begin
        counter_q[i]  = '0;
        reload_q[i]   = '0;
        load_q[i]     = '0;
        expiries_q[i] = '0;
        armed_q[i]    = 1'b0;
      end
      ticks_q = '0;
      errors  = 0;
    endfunction

    task report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [MASK_W-1:0] walk_tick();
      logic [MASK_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (!armed_q[i]) continue;
        if (counter_q[i] != '0) begin
          counter_q[i] = counter_q[i] - 1'b1;
          if (counter_q[i] == '0) begin
            expiries_q[i] = expiries_q[i] + 1'b1;
            if (i < MASK_W) mask[i] = 1'b1;
            if (reload_q[i] != '0) counter_q[i] = reload_q[i];
          end
        end
        if (load_q[i] != '0) begin
          counter_q[i] = load_q[i];
          load_q[i]    = '0;
        end
      end
      ticks_q = ticks_q + 1'b1;
      return mask;
    endfunction

    function void note_request(input in_req_t req);
      out_rsp_t               rsp;
      logic [COUNT_WIDTH-1:0] value;
      bit                     in_bank;
      int unsigned            idx;
      idx     = 32'(req.timer_index);
      in_bank = idx < NUM_TIMERS;
      value   = req.count_value[COUNT_WIDTH-1:0];
      rsp     = '0;
      case (req.mode)
        MODE_TICK: begin
          rsp.expired_mask = walk_tick();
        end
        MODE_ARM: begin
          if (in_bank) begin
            armed_q[idx]    = 1'b1;
            reload_q[idx]   = value;
            counter_q[idx]  = value;
            expiries_q[idx] = '0;
            load_q[idx]     = '0;
          end
        end
        MODE_LOAD: begin
          if (in_bank) load_q[idx] = value;
        end
        default: begin
          if (in_bank) rsp.expiry_count = expiries_q[idx];
        end
      endcase
      rsp.tick_count = ticks_q;
      expected_q.push_back(rsp);
    endfunction

    task check_response(input out_rsp_t got);
      out_rsp_t want;
      if (expected_q.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (got.expired_mask !== want.expired_mask)
          report($sformatf("expired_mask got %h want %h", got.expired_mask,
                           want.expired_mask));
        if (got.tick_count !== want.tick_count)
          report($sformatf("tick_count got %h want %h", got.tick_count,
                           want.tick_count));
        if (got.expiry_count !== want.expiry_count)
          report($sformatf("expiry_count got %h want %h", got.expiry_count,
                           want.expiry_count));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  in_req_t  in_req_i    = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  out_rsp_t out_rsp_o;

  timer_scoreboard sb = new();
  int              burst_left = 0;
  int              responses  = 0;

  countdown_timer_bank_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("countdown_timer_bank_core regression: fail");
    $finish;
  end

  function automatic in_req_t make_req(input mode_e m, input logic [3:0] idx,
                                       input logic [31:0] value);
    in_req_t req;
    req.mode        = m;
    req.timer_index = idx;
    req.count_value = value;
    return req;
  endfunction

  task automatic send_request(input in_req_t req);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 6);
    if (pick < 90) return $urandom_range(0, 40);
    return $urandom;
  endfunction

  function automatic in_req_t random_req();
    int unsigned pick;
    mode_e       m;
    pick = $urandom_range(0, 99);
    if (pick < 45)      m = MODE_TICK;
    else if (pick < 70) m = MODE_ARM;
    else if (pick < 85) m = MODE_LOAD;
    else                m = MODE_READ;
    return make_req(m, 4'($urandom_range(0, 15)), random_count());
  endfunction

  initial begin
    int unsigned duty;
    int          holds_done;
    duty       = 100;
    holds_done = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_response(out_rsp_o);
        responses++;
      end
      if ((holds_done == 0 && responses >= 400) ||
          (holds_done == 1 && responses >= 1000)) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        if ((responses % 64) == 0) duty = 100;
        else if ((responses % 64) == 16) duty = 70;
        else if ((responses % 64) == 32) duty = 30;
        else if ((responses % 64) == 48) duty = 90;
        out_ready_i <= ($urandom_range(0, 99) < duty);
      end
    end
  end

  initial begin
    burst_left = $urandom_range(1, 40);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_req(MODE_READ, 4'd0,  32'd0));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_ARM,  4'd0,  32'd1));
    send_request(make_req(MODE_ARM,  4'd15, 32'd0));
    send_request(make_req(MODE_LOAD, 4'd15, 32'd2));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_READ, 4'd15, 32'd0));
    // A load queued on an idle timer is dropped by the later arm.
    send_request(make_req(MODE_LOAD, 4'd3,  32'd5));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_ARM,  4'd3,  32'd2));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_ARM,  4'd7,  32'hFFFF_FFFF));
    send_request(make_req(MODE_LOAD, 4'd7,  32'd0));
    send_request(make_req(MODE_ARM,  4'd2,  32'd1));
    send_request(make_req(MODE_LOAD, 4'd2,  32'd4));
    send_request(make_req(MODE_ARM,  4'd5,  32'hAAAA_AAAA));
    send_request(make_req(MODE_LOAD, 4'd10, 32'h5555_5555));
    send_request(make_req(MODE_TICK, 4'd0,  32'd0));
    send_request(make_req(MODE_ARM,  4'd0,  32'd3));
    send_request(make_req(MODE_READ, 4'd0,  32'd0));
    send_request(make_req(MODE_READ, 4'd3,  32'd0));
    send_request(make_req(MODE_READ, 4'd2,  32'd0));

    repeat (1300) send_request(random_req());
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("responses still outstanding at end of run");

    if (sb.errors == 0) begin
      $display("countdown_timer_bank_core regression: pass");
    end else begin
      $display("countdown_timer_bank_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cdtb_pkg.sv
rtl/cdtb_ctrl.sv
rtl/cdtb_datapath.sv
rtl/countdown_timer_bank_core.sv
test/testbench.sv
